// ----- hw/rtl/nohf_pkg.sv -----
// Package for the nearest opaque hole fill block: sizes, register indexes,
// pixel and work-item types. No dependencies.
package nohf_pkg;
    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int Radius    = 4;
    localparam int RingRows  = 2 * Radius + 2;
    localparam int ColW      = 12;
    localparam int RowSelW   = $clog2(RingRows);
    localparam int StoreColW = $clog2(MaxWidth);
    localparam int StoreDepth = MaxWidth * RingRows;
    localparam int StoreAw   = $clog2(StoreDepth);
    localparam int NumOffsets = (2 * Radius + 1) * (2 * Radius + 1) - 1;
    localparam int OffW      = $clog2(NumOffsets + 1);
    localparam int QueueDepth = 4;
    localparam int QPtrW     = $clog2(QueueDepth);

    localparam logic [1:0] RegFillEnable  = 2'd0;
    localparam logic [1:0] RegFrameWidth  = 2'd1;
    localparam logic [1:0] RegFrameHeight = 2'd2;

    typedef logic [31:0] pixel_t;

    // One output job: position to produce, its line-store row slot and sizes in force.
    typedef struct packed {
        logic [ColW-1:0]    row;
        logic [ColW-1:0]    col;
        logic [RowSelW-1:0] slot;
        logic [ColW-1:0]    width;
        logic [ColW-1:0]    height;
        logic               fill;
        logic               last;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CENTER,
        BK_SEARCH,
        BK_SEND
    } back_state_t;

    // Signed offset for search step k: rings 1..Radius, dy then dx order.
    function automatic logic [9:0] ring_offset(input int k);
        int n;
        int r;
        int dy;
        int dx;
        logic [9:0] res;
        n = 0;
        res = '0;
        for (r = 1; r <= Radius; r++) begin
            for (dy = -r; dy <= r; dy++) begin
                for (dx = -r; dx <= r; dx++) begin
                    if (dx == -r || dx == r || dy == -r || dy == r) begin
                        if (n == k) begin
                            res = {5'(dy), 5'(dx)};
                        end
                        n++;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic logic [ColW-1:0] clamp_size(input logic [ColW-1:0] v,
                                                  input int mx);
        logic [ColW:0] m;
        m = (ColW+1)'(mx);
        if (v == '0) begin
            return ColW'(1);
        end else if ({1'b0, v} > m) begin
            return ColW'(mx);
        end
        return v;
    endfunction
endpackage

// ----- hw/rtl/nohf_front.sv -----
// Front end: takes input beats, tracks in/out positions, writes pixels
// to the line store and issues output jobs. Depends on nohf_pkg.
module nohf_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fill_enable,
    input  logic [nohf_pkg::ColW-1:0] frame_width,
    input  logic [nohf_pkg::ColW-1:0] frame_height,
    input  logic                      pipe_busy,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [31:0]               s_pixel,
    output logic                      wr_en,
    output logic [nohf_pkg::StoreAw-1:0] wr_addr,
    output logic [31:0]               wr_data,
    output logic                      job_valid,
    input  logic                      job_ready,
    output nohf_pkg::job_t            job
);
    import nohf_pkg::*;

    logic [ColW-1:0] in_col_reg, in_col_next, in_row_reg, in_row_next;
    logic [ColW-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [RowSelW-1:0] in_slot_reg, in_slot_next;
    logic [RowSelW-1:0] out_slot_reg, out_slot_next;
    logic [ColW-1:0] w, h;
    logic            done_before, accept, emit, last;
    logic [ColW-1:0] ic1, ir1;
    logic [24:0]     received, thresh;

    assign w = clamp_size(frame_width, MaxWidth);
    assign h = clamp_size(frame_height, MaxHeight);
    assign done_before = in_row_reg >= h;
    // hold input while a job is queued or still has line-store reads to do
    assign s_ready = job_ready && !pipe_busy;
    assign accept = s_valid && s_ready;

    always_comb begin
        ic1 = in_col_reg + 1'b1;
        ir1 = in_row_reg;
        if (ic1 >= w) begin
            ic1 = '0;
            ir1 = in_row_reg + 1'b1;
        end
        received = 25'(ir1) * 25'(w) + 25'(ic1);
        thresh = 25'(out_row_reg) * 25'(w) + 25'(out_col_reg)
                 + 25'(Radius) * 25'(w) + 25'(Radius);
        last = out_row_reg >= h - 1'b1 && out_col_reg >= w - 1'b1;
        emit = 1'b0;
        if (accept) begin
            if (done_before) emit = 1'b1;
            else if (!s_req_type) emit = received > thresh;
        end
    end

    assign wr_en = accept && !done_before && !s_req_type
                   && in_col_reg < ColW'(MaxWidth);
    assign wr_addr = StoreAw'(in_slot_reg) * StoreAw'(MaxWidth)
                     + StoreAw'(in_col_reg[StoreColW-1:0]);
    assign wr_data = s_pixel;
    assign job_valid = emit;
    assign job = '{row: out_row_reg, col: out_col_reg, slot: out_slot_reg,
                   width: w, height: h, fill: fill_enable, last: last};

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_slot_next = out_slot_reg;
        if (accept && !done_before && !s_req_type) begin
            in_col_next = ic1;
            in_row_next = ir1;
            if (ir1 != in_row_reg) begin
                in_slot_next = (in_slot_reg == RowSelW'(RingRows - 1)) ? '0
                               : in_slot_reg + 1'b1;
            end
        end
        if (emit) begin
            if (last) begin
                in_col_next = '0;
                in_row_next = '0;
                in_slot_next = '0;
                out_col_next = '0;
                out_row_next = '0;
                out_slot_next = '0;
            end else if (out_col_reg + 1'b1 >= w) begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
                out_slot_next = (out_slot_reg == RowSelW'(RingRows - 1)) ? '0
                                : out_slot_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_slot_reg <= '0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            in_slot_reg <= in_slot_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end
endmodule

// ----- hw/rtl/nohf_queue.sv -----
// Short job queue between front and back ends. Depends on nohf_pkg.
module nohf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  nohf_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output nohf_pkg::job_t out_job
);
    import nohf_pkg::*;

    job_t           mem_reg [QueueDepth];
    logic [QPtrW-1:0] wp_reg, rp_reg;
    logic [QPtrW:0]   cnt_reg;
    logic           push, pop;

    assign in_ready = cnt_reg != (QPtrW+1)'(QueueDepth);
    assign out_valid = cnt_reg != '0;
    assign out_job = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/nohf_back.sv -----
// Back end: reads the centre pixel and walks ring offsets through the line
// store, one read per cycle, then holds the result. Depends on nohf_pkg.
module nohf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  nohf_pkg::job_t job,
    output logic           busy,
    input  logic           wr_en,
    input  logic [nohf_pkg::StoreAw-1:0] wr_addr,
    input  logic [31:0]    wr_data,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_pixel,
    output logic           m_last
);
    import nohf_pkg::*;

    logic [31:0]      store_mem [StoreDepth];
    logic [31:0]      rd_data_reg;
    logic [StoreAw-1:0] rd_addr;
    logic             rd_en, rd_ok_reg, rd_ok;
    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [OffW-1:0]  k_reg, k_next;
    logic [31:0]      pix_reg, pix_next;
    logic [9:0]       off;
    logic signed [ColW+1:0] ny, nx;
    logic signed [RowSelW+1:0] slot_sum;
    logic [RowSelW-1:0] slot;

    always_ff @(posedge aclk) begin
        if (wr_en) store_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= store_mem[rd_addr];
    end

    // Address of current probe: centre when idle, else ring offset k.
    always_comb begin
        off = (state_reg == BK_SEARCH || state_reg == BK_CENTER)
              ? ring_offset(int'(k_reg)) : '0;
        if (state_reg == BK_IDLE) off = '0;
        ny = $signed({2'b0, job_reg.row}) + (ColW+2)'($signed(off[9:5]));
        nx = $signed({2'b0, job_reg.col}) + (ColW+2)'($signed(off[4:0]));
        // wrap the row slot back into the ring
        slot_sum = $signed({2'b0, job_reg.slot}) + (RowSelW+2)'($signed(off[9:5]));
        if (slot_sum < 0) slot_sum = slot_sum + (RowSelW+2)'(RingRows);
        else if (slot_sum >= (RowSelW+2)'(RingRows))
            slot_sum = slot_sum - (RowSelW+2)'(RingRows);
        if (state_reg == BK_IDLE) begin
            ny = $signed({2'b0, job.row});
            nx = $signed({2'b0, job.col});
            slot_sum = $signed({2'b0, job.slot});
        end
        slot = RowSelW'(slot_sum);
        rd_ok = ny >= 0 && nx >= 0
                && ny < $signed({2'b0, job_reg.height})
                && nx < $signed({2'b0, job_reg.width});
        if (state_reg == BK_IDLE) rd_ok = 1'b1;
        rd_addr = StoreAw'(slot) * StoreAw'(MaxWidth) + StoreAw'(nx[StoreColW-1:0]);
        rd_en = (state_reg == BK_IDLE && job_valid) || state_reg == BK_CENTER
                || state_reg == BK_SEARCH;
    end

    assign job_ready = state_reg == BK_IDLE;
    assign busy = state_reg == BK_CENTER || state_reg == BK_SEARCH;
    assign m_valid = state_reg == BK_SEND;
    assign m_pixel = pix_reg;
    assign m_last = job_reg.last;

    always_comb begin
        state_next = state_reg;
        job_next = job_reg;
        k_next = k_reg;
        pix_next = pix_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_next = job;
                    k_next = '0;
                    state_next = BK_CENTER;
                end
            end
            BK_CENTER: begin
                // centre data lands now; probe for offset 0 issued alongside
                pix_next = rd_data_reg;
                k_next = k_reg + 1'b1;
                if (!job_reg.fill || rd_data_reg[31:24] != 8'd0) state_next = BK_SEND;
                else state_next = BK_SEARCH;
            end
            BK_SEARCH: begin
                // data for offset k-1 is back
                if (rd_ok_reg && rd_data_reg[31:24] != 8'd0) begin
                    pix_next = rd_data_reg;
                    state_next = BK_SEND;
                end else if (k_reg == OffW'(NumOffsets)) begin
                    state_next = BK_SEND;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            BK_SEND: begin
                if (m_ready) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            rd_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_ok_reg <= rd_ok && k_reg < OffW'(NumOffsets);
        end
        job_reg <= job_next;
        k_reg <= k_next;
        pix_reg <= pix_next;
    end
endmodule

// ----- hw/rtl/nearest_opaque_hole_fill.sv -----
// Nearest opaque hole fill: RGBA stream in raster order, holes filled from
// the nearest opaque ring pixel within Radius. Delays output by Radius rows
// and Radius columns; flush beats (s_req_type = 1) drain the tail.
// Input on s_* (valid/ready), results on m_* (valid/ready), config via
// cfg_wr_en / cfg_index / cfg_data, to be written only while idle; the
// block itself does not enforce this. An output job is issued in the cycle
// its trigger beat is accepted and pushed into the job queue; the back end
// takes it when idle, reads the centre pixel and, for a hole with fill on,
// probes ring offsets in order until an opaque pixel or the last offset.
// Throughput: one input beat per cycle while no job is pending; after a beat
// that issues a job, s_ready stays low until the back end finishes its
// line-store reads. The reads thus see the store as it was at issue.
// Reset: counters zero, fill_enable = 1, width 640, height 480; the line
// store is not cleared. When m_ready is low the result is held; the next
// job waits in the job queue and s_ready stays low until the result is taken.
module nearest_opaque_hole_fill (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [7:0]  s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic [7:0]  m_alpha_out,
    output logic        m_frame_done
);
    import nohf_pkg::*;

    logic            fill_reg;
    logic [ColW-1:0] width_reg, height_reg;
    logic            f_valid, f_ready, q_valid, q_ready, bk_busy;
    job_t            f_job, q_job;
    logic            wr_en;
    logic [StoreAw-1:0] wr_addr;
    logic [31:0]     wr_data, px;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 1'b1;
            width_reg <= 12'd640;
            height_reg <= 12'd480;
        end else if (cfg_wr_en) begin
            if (cfg_index == RegFillEnable) fill_reg <= cfg_data[0];
            if (cfg_index == RegFrameWidth) width_reg <= cfg_data;
            if (cfg_index == RegFrameHeight) height_reg <= cfg_data;
        end
    end

    nohf_front u_front (
        .aclk, .aresetn,
        .fill_enable(fill_reg), .frame_width(width_reg), .frame_height(height_reg),
        .pipe_busy(q_valid || bk_busy),
        .s_valid, .s_ready, .s_req_type,
        .s_pixel({s_alpha_in, s_blue_in, s_green_in, s_red_in}),
        .wr_en, .wr_addr, .wr_data,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    nohf_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    nohf_back u_back (
        .aclk, .aresetn,
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .busy(bk_busy),
        .wr_en, .wr_addr, .wr_data,
        .m_valid, .m_ready, .m_pixel(px), .m_last(m_frame_done)
    );

    assign m_red_out = px[7:0];
    assign m_green_out = px[15:8];
    assign m_blue_out = px[23:16];
    assign m_alpha_out = px[31:24];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(px))
        else $error("result changed while stalled");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_ready |-> !s_ready)
        else $error("input taken with queue full");
    a_job: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid |-> f_ready)
        else $error("job lost");
endmodule

// ----- verif/nearest_opaque_hole_fill_tb.sv -----
`timescale 1ns / 1ps
// Testbench for nearest_opaque_hole_fill: frames of random RGBA pixels plus flush beats,
// checked against a ring-search hole-fill predictor kept in a scoreboard class.
// Depends on nohf_pkg and the nearest_opaque_hole_fill RTL.
module nearest_opaque_hole_fill_tb;
    import nohf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       done;
    } out_pixel_t;

    class fill_scoreboard;
        pixel_t      store [RingRows][MaxWidth];
        int unsigned in_col, in_row, out_col, out_row;
        bit          fill_en;
        int unsigned width_reg, height_reg;
        out_pixel_t  pending[$];

        function new();
            fill_en = 1;
            width_reg = 640;
            height_reg = 480;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            for (int i = 0; i < RingRows; i++)
                for (int j = 0; j < MaxWidth; j++) store[i][j] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] v);
            case (idx)
                RegFillEnable:  fill_en = v[0];
                RegFrameWidth:  width_reg = v;
                RegFrameHeight: height_reg = v;
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned mx);
            if (v < 1) return 1;
            if (v > mx) return mx;
            return v;
        endfunction

        function bit busy();
            return in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0;
        endfunction

        function pixel_t rd(int unsigned row, int unsigned col);
            if (col >= MaxWidth) return '0;
            return store[row % RingRows][col];
        endfunction

        // nearest opaque pixel on rings 1..Radius, dy outer, dx inner
        function pixel_t nearest_fill(int unsigned row, int unsigned col,
                                      int unsigned w, int unsigned h);
            pixel_t center;
            pixel_t p;
            int ny;
            int nx;
            center = rd(row, col);
            if (!fill_en || center[31:24] != 0) return center;
            for (int r = 1; r <= Radius; r++)
                for (int dy = -r; dy <= r; dy++)
                    for (int dx = -r; dx <= r; dx++) begin
                        if (dx != -r && dx != r && dy != -r && dy != r) continue;
                        ny = int'(row) + dy;
                        nx = int'(col) + dx;
                        if (ny < 0 || nx < 0 || ny >= int'(h) || nx >= int'(w)) continue;
                        p = rd(ny, nx);
                        if (p[31:24] != 0) return p;
                    end
            return center;
        endfunction

        function void note_beat(bit flush, pixel_t pix);
            int unsigned w;
            int unsigned h;
            int unsigned got_in;
            int unsigned out_idx;
            pixel_t      px;
            bit          last;
            out_pixel_t  e;
            w = clamp(width_reg, MaxWidth);
            h = clamp(height_reg, MaxHeight);
            if (in_row < h) begin
                if (flush) return;
                if (in_col < MaxWidth) store[in_row % RingRows][in_col] = pix;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row = (in_row + 1) & 12'hFFF;
                end
                got_in = in_row * w + in_col;
                out_idx = out_row * w + out_col;
                if (got_in <= out_idx + Radius * w + Radius) return;
            end
            px = nearest_fill(out_row, out_col, w, h);
            last = out_row >= h - 1 && out_col >= w - 1;
            if (last) begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row = (out_row + 1) & 12'hFFF;
                end
            end
            e.red = px[7:0];
            e.green = px[15:8];
            e.blue = px[23:16];
            e.alpha = px[31:24];
            e.done = last;
            pending.insert(pending.size(), e);
        endfunction

        function string check(out_pixel_t got);
            out_pixel_t e;
            if (pending.size() == 0) return $sformatf("unexpected beat %h", got);
            e = pending.pop_front();
            if (got.red != e.red) return $sformatf("red %h, want %h", got.red, e.red);
            if (got.green != e.green) return $sformatf("green %h, want %h", got.green, e.green);
            if (got.blue != e.blue) return $sformatf("blue %h, want %h", got.blue, e.blue);
            if (got.alpha != e.alpha) return $sformatf("alpha %h, want %h", got.alpha, e.alpha);
            if (got.done != e.done) return $sformatf("frame_done %b, want %b", got.done, e.done);
            return "";
        endfunction
    endclass

    localparam int StallLimit = 5000;
    localparam int DrainWait  = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic [7:0]  s_alpha_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic [7:0]  m_alpha_out;
    logic        m_frame_done;

    fill_scoreboard sb;
    int  errors;
    int  idle_cycles;
    int  in_beats;
    bit  steady;

    nearest_opaque_hole_fill dut (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            msg = sb.check({m_red_out, m_green_out, m_blue_out, m_alpha_out, m_frame_done});
            if (msg != "") report(msg);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [11:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    // one beat; valid is only lowered for a random gap or at frame end
    task automatic send_beat(bit flush, pixel_t pix);
        while (!steady && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= flush;
        {s_alpha_in, s_blue_in, s_green_in, s_red_in} <= pix;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(flush, pix);
        in_beats++;
    endtask

    function automatic pixel_t rand_pixel(int hole_pct);
        pixel_t p;
        p = $urandom;
        case ($urandom_range(19))
            0: p = '0;
            1: p = '1;
            default: p[31:24] = ($urandom_range(99) < hole_pct) ? 8'd0 : 8'($urandom_range(1, 255));
        endcase
        return p;
    endfunction

    task automatic run_frame(logic [11:0] w, logic [11:0] h, bit fill, int hole_pct,
                             int noise_pct);
        int n;
        n = sb.clamp(w, MaxWidth) * sb.clamp(h, MaxHeight);
        cfg_write(RegFillEnable, {11'd0, fill});
        cfg_write(RegFrameWidth, w);
        cfg_write(RegFrameHeight, h);
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < n; i++) begin
            // early flushes are ignored by the block
            if ($urandom_range(99) < noise_pct) send_beat(1'b1, $urandom);
            send_beat(1'b0, rand_pixel(hole_pct));
        end
        // drain the tail; a late pixel acts as a flush
        while (sb.busy())
            send_beat(($urandom_range(99) >= noise_pct), $urandom);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
    endtask

    initial begin
        int frames;
        sb = new();
        errors = 0;
        in_beats = 0;
        steady = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = RegFillEnable;
        cfg_data = '0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        s_alpha_in = '0;
        m_ready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_frame(12'd1, 12'd1, 1'b1, 50, 20);
        run_frame(12'd3, 12'd3, 1'b1, 100, 10);
        run_frame(12'd5, 12'd4, 1'b1, 85, 10);
        run_frame(12'd5, 12'd4, 1'b0, 60, 10);
        run_frame(12'd0, 12'd0, 1'b1, 50, 30);
        run_frame(12'd9, 12'd9, 1'b1, 95, 5);
        run_frame(12'd40, 12'd3, 1'b1, 70, 0);

        frames = 0;
        while (in_beats < 1200) begin
            steady = (frames >= 6 && frames < 10);
            run_frame(($urandom_range(9) == 0) ? 12'($urandom_range(13, 40))
                                               : 12'($urandom_range(1, 12)),
                      12'($urandom_range(1, 10)), ($urandom_range(4) != 0),
                      $urandom_range(100), $urandom_range(8));
            frames++;
        end

        if (errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (sb.pending.size() != 0) report($sformatf("%0d beats missing", sb.pending.size()));
            $display("FAILURE");
        end
        $finish;
    end
endmodule
